FILE: hdl/bcc_pkg.sv
package bcc_pkg;

   localparam int NUM_BUTTONS_DEF = 8;
   localparam int MASK_W          = 8;
   localparam int TIME_W          = 16;
   localparam int CNT_W           = 8;
   localparam int BTN_IDX_W       = 3;
   localparam int CSR_IDX_W       = 3;

   localparam logic [TIME_W-1:0] DUR_MAX = 16'hFFFF;
   localparam logic [CNT_W-1:0]  CNT_MAX = 8'hFF;

   localparam logic [TIME_W-1:0] CLICK_TIME_RST  = 16'd50;
   localparam logic [TIME_W-1:0] LONG_TIME_RST   = 16'd1000;
   localparam logic [TIME_W-1:0] DCLICK_GAP_RST  = 16'd300;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED_MASK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_TIME      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_CLICK_TIME = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DCLICK_GAP      = 3'd4;

   localparam logic EV_CLICK      = 1'b0;
   localparam logic EV_LONG_CLICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   // one button's stored state
   typedef struct packed {
      logic [TIME_W-1:0] dur;
      logic              pressed;
      logic [CNT_W-1:0]  cnt;
   } entry_type;

   typedef struct packed {
      logic [BTN_IDX_W-1:0] idx;
      logic                 kind;
      logic [CNT_W-1:0]     cnt;
   } event_type;

endpackage

FILE: hdl/button_click_classifier_unit.sv
// Button click classifier.
// Input channel req_*: one beat per sample, carrying the ms elapsed since the
// previous sample and the raw pin level of each button. Result channel rsp_*:
// one beat per click or long-click event, in ascending button order, with
// rsp_last set on the final event of a sample. A sample with no events gives
// no beat at all.
// Configuration csr_*: a write is taken on any cycle csr_wr_en is high;
// unknown indexes are ignored. Write only while the block is idle.
// Sweep: per-button state sits in a small synchronous RAM and each button
// gets a read-modify-write of its entry, in ascending order. req_ready stays
// low from acceptance until the sweep is done and the held event has gone to
// the output register, so a new sample is not taken while the last one is
// still being processed.
// One event is held back until the next one (or the end of the sample) is
// known, so that last can be set. If the receiver stalls with an event in the
// output register and another held, the sweep stalls on the next button with
// an event until the output register frees up; nothing is dropped.
// Reset: thresholds go to 50/1000/300 ms, masks to zero, and all button state
// reads as zero through per-entry valid bits; no clearing pass is needed.
module button_click_classifier_unit
   import bcc_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_elapsed_ms,
   input  logic [MASK_W-1:0]    req_pin_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BTN_IDX_W-1:0] rsp_button_index,
   output logic                 rsp_event_kind,
   output logic [CNT_W-1:0]     rsp_click_count,
   output logic                 rsp_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

   // configuration
   logic [MASK_W-1:0] enabled_mask_ff;
   logic [MASK_W-1:0] active_level_ff;
   logic [TIME_W-1:0] click_time_ff;
   logic [TIME_W-1:0] long_time_ff;
   logic [TIME_W-1:0] dclick_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_mask_ff <= '0;
         active_level_ff <= '0;
         click_time_ff   <= CLICK_TIME_RST;
         long_time_ff    <= LONG_TIME_RST;
         dclick_gap_ff   <= DCLICK_GAP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLED_MASK:    enabled_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_ACTIVE_LEVEL:    active_level_ff <= csr_wdata[MASK_W-1:0];
            CSR_CLICK_TIME:      click_time_ff   <= csr_wdata;
            CSR_LONG_CLICK_TIME: long_time_ff    <= csr_wdata;
            CSR_DCLICK_GAP:      dclick_gap_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic [TIME_W-1:0] elapsed_ff;
   logic [MASK_W-1:0] pins_ff;

   // state RAM
   entry_type        mem [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] valid_ff;
   entry_type        rd_entry_ff;
   logic             rd_valid_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   // event held back until we know whether it is the last one
   logic      hold_valid_ff, hold_valid_in;
   event_type hold_ff, hold_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_ev_ff, rsp_ev_in;
   logic      rsp_last_ff, rsp_last_in;

   // per-button datapath
   logic [31:0]       idx_ext;
   logic              btn_on;
   entry_type         cur, upd;
   logic [TIME_W:0]   dur_sum;
   logic [TIME_W-1:0] dur_sat;
   logic              lvl_active;
   logic              ev_valid;
   event_type         ev;

   logic accept, rsp_free, last_step, advance;

   assign idx_ext  = 32'(proc_idx_ff);
   assign btn_on   = (idx_ext[31:3] == '0) && enabled_mask_ff[idx_ext[2:0]];
   assign cur      = rd_valid_ff ? rd_entry_ff : '0;
   assign dur_sum  = {1'b0, cur.dur} + {1'b0, elapsed_ff};
   assign dur_sat  = (dur_sum >= {1'b0, DUR_MAX}) ? DUR_MAX : dur_sum[TIME_W-1:0];
   assign lvl_active = pins_ff[idx_ext[2:0]] == active_level_ff[idx_ext[2:0]];

   always_comb begin
      upd      = cur;
      ev_valid = 1'b0;
      ev.idx   = idx_ext[BTN_IDX_W-1:0];
      ev.kind  = EV_CLICK;
      ev.cnt   = cur.cnt;
      if (btn_on) begin
         upd.dur = dur_sat;
         if (lvl_active) begin
            if (!cur.pressed) begin
               if (dur_sat > dclick_gap_ff) begin
                  upd.cnt = '0;
               end
               upd.dur     = '0;
               upd.pressed = 1'b1;
            end
         end else if (cur.pressed) begin
            if (dur_sat >= long_time_ff) begin
               ev_valid = 1'b1;
               ev.kind  = EV_LONG_CLICK;
               ev.cnt   = cur.cnt;
               upd.cnt  = '0;
            end else if (dur_sat >= click_time_ff) begin
               if (cur.cnt != CNT_MAX) begin
                  upd.cnt = cur.cnt + 1'b1;
               end
               ev_valid = 1'b1;
               ev.kind  = EV_CLICK;
               ev.cnt   = upd.cnt;
            end
            upd.pressed = 1'b0;
            upd.dur     = '0;
         end
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = proc_idx_ff == LAST_IDX;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_RUN;
         ST_RUN:   if (advance && last_step) state_in = ST_FLUSH;
         ST_FLUSH: if (!hold_valid_ff || rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready     = 1'b0;
      advance       = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      proc_idx_in   = proc_idx_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ev_in     = rsp_ev_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            rd_en       = req_valid;
            proc_idx_in = '0;
         end
         ST_RUN: begin
            // a second event can only be taken once the held one can move on
            advance = !(ev_valid && hold_valid_ff && !rsp_free);
            if (advance) begin
               mem_we      = 1'b1;
               proc_idx_in = IDX_W'(proc_idx_ff + 1'b1);
               rd_en       = !last_step;
               rd_addr     = proc_idx_in;
               if (ev_valid) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_ev_in    = hold_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_in       = ev;
               end
            end
         end
         ST_FLUSH: begin
            if (hold_valid_ff && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ev_in     = hold_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         proc_idx_ff   <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         proc_idx_ff   <= proc_idx_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mem_we) begin
            valid_ff[proc_idx_ff] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elapsed_ff <= req_elapsed_ms;
         pins_ff    <= req_pin_levels;
      end
      hold_ff     <= hold_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_last_ff <= rsp_last_in;
   end

   // RAM: reads and writes never hit the same entry in one cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[proc_idx_ff] <= upd;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_button_index = rsp_ev_ff.idx;
   assign rsp_event_kind   = rsp_ev_ff.kind;
   assign rsp_click_count  = rsp_ev_ff.cnt;
   assign rsp_last         = rsp_last_ff;

   // the held event is always flushed before a new sample starts
   a_idle_no_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held event left over in idle");

   a_we_in_run: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_RUN))
      else $error("state RAM written outside the sweep");

   a_stall_holds_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && !advance) |=> (state_ff == ST_RUN) && $stable(proc_idx_ff))
      else $error("sweep moved on while stalled");

   a_event_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && ev_valid) |-> (idx_ext[31:3] == '0))
      else $error("event raised for a button without a mask bit");

endmodule

FILE: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bcc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int IDLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES = 20;
   localparam int DIRECTED_LEN = 30;
   localparam int RAND_PHASES  = 6;
   localparam int PHASE_ITEMS  = 18;
   localparam int SAT_PAIRS    = 10;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD5 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD7 = 3'd7;

   typedef struct packed {
      logic [BTN_IDX_W-1:0] idx;
      logic                 kind;
      logic [CNT_W-1:0]     cnt;
      logic                 last;
   } click_event_type;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PREDICT,
      ROW_QUIET,
      ROW_EVENT
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [TIME_W-1:0]    value;
      logic [MASK_W-1:0]    pins;
      logic [BTN_IDX_W-1:0] ev_idx;
      logic                 ev_kind;
      logic [CNT_W-1:0]     ev_cnt;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_elapsed_ms = '0;
   logic [MASK_W-1:0]    req_pin_levels = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BTN_IDX_W-1:0] rsp_button_index;
   logic                 rsp_event_kind;
   logic [CNT_W-1:0]     rsp_click_count;
   logic                 rsp_last;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   // hand-computed expectation travelling with the current beat
   logic            row_typed = 1'b0;
   logic            row_has_event = 1'b0;
   click_event_type row_event = '0;

   // predictor copy of the registers and per-button state
   logic [MASK_W-1:0] cfg_enabled = '0;
   logic [MASK_W-1:0] cfg_active = '0;
   logic [TIME_W-1:0] cfg_click = CLICK_TIME_RST;
   logic [TIME_W-1:0] cfg_long = LONG_TIME_RST;
   logic [TIME_W-1:0] cfg_gap = DCLICK_GAP_RST;
   logic [TIME_W-1:0] btn_dur [0:7];
   logic              btn_down [0:7];
   logic [CNT_W-1:0]  btn_clicks [0:7];

   click_event_type sample_events [0:7];
   click_event_type pending_events [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit traffic_since_write = 1'b0;

   stim_row_type directed_rows [0:DIRECTED_LEN-1] = '{
      '{ROW_QUIET,   '0,                 16'd1234, 8'hFF, '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_ENABLED_MASK,   16'h0001, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_ACTIVE_LEVEL,   16'h0001, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_RSVD5,          16'h0000, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_RSVD6,          16'h0000, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_RSVD7,          16'h0000, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_QUIET,   '0,                 DUR_MAX,  8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 DUR_MAX,  8'h00, '0, EV_LONG_CLICK, 8'd0},
      '{ROW_QUIET,   '0,                 16'd10,   8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 16'd60,   8'h00, '0, EV_CLICK,      8'd1},
      '{ROW_QUIET,   '0,                 16'd100,  8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_QUIET,   '0,                 16'd49,   8'h00, '0, EV_CLICK,      8'd0},
      '{ROW_QUIET,   '0,                 16'd0,    8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 16'd50,   8'h00, '0, EV_CLICK,      8'd2},
      '{ROW_QUIET,   '0,                 16'd301,  8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 16'd1000, 8'h00, '0, EV_LONG_CLICK, 8'd0},
      '{ROW_QUIET,   '0,                 16'd0,    8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_ENABLED_MASK,   16'h0000, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_QUIET,   '0,                 16'd5000, 8'h00, '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_ENABLED_MASK,   16'h0001, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 16'd60,   8'hFE, '0, EV_CLICK,      8'd1},
      '{ROW_QUIET,   '0,                 16'd300,  8'h01, '0, EV_CLICK,      8'd0},
      '{ROW_EVENT,   '0,                 16'd999,  8'h00, '0, EV_CLICK,      8'd2},
      '{ROW_CSR,     CSR_ENABLED_MASK,   16'h00FF, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_CSR,     CSR_ACTIVE_LEVEL,   16'h00A5, '0,    '0, EV_CLICK,      8'd0},
      '{ROW_PREDICT, '0,                 16'd0,    8'hA5, '0, EV_CLICK,      8'd0},
      '{ROW_PREDICT, '0,                 16'd2000, 8'h5A, '0, EV_CLICK,      8'd0},
      '{ROW_PREDICT, '0,                 16'd100,  8'hA5, '0, EV_CLICK,      8'd0},
      '{ROW_PREDICT, '0,                 16'd200,  8'h5A, '0, EV_CLICK,      8'd0},
      '{ROW_PREDICT, '0,                 16'd40,   8'hF0, '0, EV_CLICK,      8'd0}
   };

   button_click_classifier_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elapsed_ms   (req_elapsed_ms),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_button_index (rsp_button_index),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_click_count  (rsp_click_count),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int b = 0; b < 8; b++) begin
         btn_dur[b] = '0;
         btn_down[b] = 1'b0;
         btn_clicks[b] = '0;
      end
   end

   // Advances the button state by one sample; fills sample_events and
   // returns how many events it produced.
   function automatic int classify_sample(input logic [TIME_W-1:0] ms,
                                          input logic [MASK_W-1:0] pins);
      int n;
      logic [TIME_W:0] sum;
      n = 0;
      for (int b = 0; b < 8; b++) begin
         if (cfg_enabled[b]) begin
            sum = {1'b0, btn_dur[b]} + {1'b0, ms};
            btn_dur[b] = (sum >= {1'b0, DUR_MAX}) ? DUR_MAX : sum[TIME_W-1:0];
            if (pins[b] == cfg_active[b]) begin
               if (!btn_down[b]) begin
                  if (btn_dur[b] > cfg_gap)
                     btn_clicks[b] = '0;
                  btn_dur[b] = '0;
                  btn_down[b] = 1'b1;
               end
            end else if (btn_down[b]) begin
               if (btn_dur[b] >= cfg_long) begin
                  sample_events[n] = '{3'(b), EV_LONG_CLICK, btn_clicks[b], 1'b0};
                  btn_clicks[b] = '0;
                  n++;
               end else if (btn_dur[b] >= cfg_click) begin
                  if (btn_clicks[b] != CNT_MAX)
                     btn_clicks[b] = btn_clicks[b] + 1'b1;
                  sample_events[n] = '{3'(b), EV_CLICK, btn_clicks[b], 1'b0};
                  n++;
               end
               btn_down[b] = 1'b0;
               btn_dur[b] = '0;
            end
         end
      end
      if (n > 0)
         sample_events[n-1].last = 1'b1;
      return n;
   endfunction

   // one sample beat; bursts of random length, random gaps between them
   task automatic send_sample(input logic [TIME_W-1:0] ms, input logic [MASK_W-1:0] pins,
                              input logic typed, input logic has_ev,
                              input click_event_type ev);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_elapsed_ms <= ms;
      req_pin_levels <= pins;
      row_typed      <= typed;
      row_has_event  <= has_ev;
      row_event      <= ev;
      traffic_since_write = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // register write, only once the block has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      if (traffic_since_write) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (pending_events.size() != 0) @(posedge clock);
         // a sample with no events may still be sweeping
         repeat (IDLE_CYCLES) @(posedge clock);
         traffic_since_write = 1'b0;
      end
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ENABLED_MASK:    cfg_enabled = val[MASK_W-1:0];
         CSR_ACTIVE_LEVEL:    cfg_active = val[MASK_W-1:0];
         CSR_CLICK_TIME:      cfg_click = val;
         CSR_LONG_CLICK_TIME: cfg_long = val;
         CSR_DCLICK_GAP:      cfg_gap = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // receiver: stall mode redrawn at random each time cycle_count[5:0] is zero
   always @(posedge clock) begin
      int stall_mode;
      if (cycle_count[5:0] == 6'd0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= cycle_count[3];
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // prediction on each accepted sample, checking on each accepted event beat
   always @(posedge clock) begin
      click_event_type got;
      click_event_type want;
      int n;
      if (!reset) begin
         if (req_valid && req_ready) begin
            n = classify_sample(req_elapsed_ms, req_pin_levels);
            if (row_typed) begin
               if (row_has_event)
                  pending_events.push_back(row_event);
            end else begin
               for (int k = 0; k < n; k++)
                  pending_events.push_back(sample_events[k]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_button_index, rsp_event_kind, rsp_click_count, rsp_last};
            if (pending_events.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat, expected none, got idx %0d kind %0d cnt %0d last %0d",
                        $time, got.idx, got.kind, got.cnt, got.last);
            end else begin
               want = pending_events.pop_front();
               if (got.idx !== want.idx) begin
                  mismatch_count++;
                  $display("%0t: button_index expected %0d, got %0d", $time, want.idx, got.idx);
               end
               if (got.kind !== want.kind) begin
                  mismatch_count++;
                  $display("%0t: event_kind (btn %0d) expected %0d, got %0d",
                           $time, want.idx, want.kind, got.kind);
               end
               if (got.cnt !== want.cnt) begin
                  mismatch_count++;
                  $display("%0t: click_count (btn %0d) expected %0d, got %0d",
                           $time, want.idx, want.cnt, got.cnt);
               end
               if (got.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last (btn %0d) expected %0d, got %0d",
                           $time, want.idx, want.last, got.last);
               end
            end
         end
      end
   end

   initial begin
      logic [MASK_W-1:0] en;
      logic [MASK_W-1:0] act;
      logic [TIME_W-1:0] ck;
      logic [TIME_W-1:0] lg;
      logic [TIME_W-1:0] gp;
      logic [TIME_W-1:0] ms;
      logic [MASK_W-1:0] pins;
      logic [MASK_W-1:0] prev_pins;
      stim_row_type row;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR)
            write_reg(row.csr_idx, row.value);
         else
            send_sample(row.value, row.pins, row.kind != ROW_PREDICT, row.kind == ROW_EVENT,
                        '{row.ev_idx, row.ev_kind, row.ev_cnt, 1'b1});
      end

      prev_pins = 8'hF0;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: begin
               en = 8'hFF; act = 8'($urandom);
               ck = CLICK_TIME_RST; lg = LONG_TIME_RST; gp = DCLICK_GAP_RST;
            end
            1: begin
               // every release is a long click
               en = 8'hFF; act = 8'h00; ck = '0; lg = '0; gp = '0;
            end
            2: begin
               en = 8'hFF; act = 8'hFF; ck = DUR_MAX; lg = DUR_MAX; gp = DUR_MAX;
            end
            default: begin
               en = 8'($urandom); act = 8'($urandom);
               ck = TIME_W'($urandom_range(0, 200));
               lg = TIME_W'($urandom_range(0, 1500));
               gp = TIME_W'($urandom_range(0, 600));
            end
         endcase
         write_reg(CSR_ENABLED_MASK, {8'h00, en});
         write_reg(CSR_ACTIVE_LEVEL, {8'h00, act});
         write_reg(CSR_CLICK_TIME, ck);
         write_reg(CSR_LONG_CLICK_TIME, lg);
         write_reg(CSR_DCLICK_GAP, gp);
         repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: ms = TIME_W'($urandom_range(0, 120));
               4, 5, 6:    ms = TIME_W'($urandom_range(0, 1500));
               7:          ms = $urandom_range(0, 1) ? DUR_MAX : '0;
               default:    ms = TIME_W'($urandom_range(0, 65535));
            endcase
            // mostly a few pins toggling, now and then a fresh pattern
            if ($urandom_range(0, 3) == 0)
               pins = 8'($urandom);
            else
               pins = prev_pins ^ 8'($urandom & $urandom);
            prev_pins = pins;
            send_sample(ms, pins, 1'b0, 1'b0, '0);
         end
      end

      // every release a click and the count never clears, so counts build up
      act = 8'($urandom);
      write_reg(CSR_ENABLED_MASK, 16'h00FF);
      write_reg(CSR_ACTIVE_LEVEL, {8'h00, act});
      write_reg(CSR_CLICK_TIME, '0);
      write_reg(CSR_LONG_CLICK_TIME, DUR_MAX);
      write_reg(CSR_DCLICK_GAP, DUR_MAX);
      repeat (SAT_PAIRS) begin
         send_sample(TIME_W'($urandom_range(0, 16'hFFFE)), act, 1'b0, 1'b0, '0);
         send_sample(TIME_W'($urandom_range(0, 16'hFFFE)), ~act, 1'b0, 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_events.size() != 0)
         $display("%0t: %0d expected beats never arrived", $time, pending_events.size());
      if (mismatch_count == 0 && pending_events.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
